// ===== rtl/sla_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sla_pkg
// Shared constants and types of the serial line assembler.
// ----------------------------------------------------------------------------
package sla_pkg;

  localparam int STORE_DEPTH = 64;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int LEN_W       = 6;
  localparam int IDX_W       = 6;

  localparam logic [1:0] CMD_BYTE    = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_READ    = 2'd2;

  localparam logic [7:0] CHAR_BACKSPACE = 8'h08;
  localparam logic [7:0] CHAR_CR        = 8'h0D;
  localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic [ADDR_W-1:0] bs_raddr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } store_ctrl_t;

endpackage

// ===== rtl/sla_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sla_if
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface sla_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] rx_byte;
  logic [5:0] read_index;

  modport source (output valid, cmd, rx_byte, read_index, input ready);
  modport sink (input valid, cmd, rx_byte, read_index, output ready);
endinterface

interface sla_rsp_if;
  logic       valid;
  logic       ready;
  logic       line_ready;
  logic       overrun;
  logic       line_done;
  logic [5:0] line_length;
  logic [7:0] read_data;

  modport source (output valid, line_ready, overrun, line_done, line_length, read_data,
                  input ready);
  modport sink (input valid, line_ready, overrun, line_done, line_length, read_data,
                output ready);
endinterface

// ===== rtl/sla_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sla_store
// Line store with a registered read port, plus a one-bit shadow store that
// marks backslash entries and keeps the flag of the last held byte on hand.
// ----------------------------------------------------------------------------
module sla_store
  import sla_pkg::*;
(
  input  logic        clk,
  input  store_ctrl_t ctrl,
  output logic [7:0]  rd_data,
  output logic        prev_bs
);

  logic [7:0] data_mem [STORE_DEPTH];
  logic       bs_mem   [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (ctrl.we) begin
      data_mem[ctrl.waddr] <= ctrl.wdata;
      bs_mem[ctrl.waddr]   <= (ctrl.wdata == CHAR_BACKSLASH);
    end
    if (ctrl.rd_en) begin
      rd_data <= data_mem[ctrl.rd_addr];
    end
    // The byte below the new fill count may be the one written at this edge.
    if (ctrl.we && (ctrl.waddr == ctrl.bs_raddr)) begin
      prev_bs <= (ctrl.wdata == CHAR_BACKSLASH);
    end else begin
      prev_bs <= bs_mem[ctrl.bs_raddr];
    end
  end

endmodule

// ===== rtl/serial_line_assembler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_line_assembler
// Collects received bytes into a line store with backspace, escaped carriage
// return, overrun flag, release and read-back of stored entries.
// ----------------------------------------------------------------------------
//  channel  direction  carries
//  req      in         cmd, rx_byte, read_index
//  rsp      out        line_ready, overrun, line_done, line_length, read_data
//
// One item per cycle while the result channel is taken; each item passes
// from the input register into the result register.
// The line store read port is registered and loads with the result register.
// Reset clears the fill count, the flags and both valid bits; the store is
// not cleared. A stalled result holds the input register, which then holds
// the request channel.
// ----------------------------------------------------------------------------
module serial_line_assembler
  import sla_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  sla_req_if.sink   req,
  sla_rsp_if.source rsp
);

  logic              s1_valid;
  logic [1:0]        s1_cmd;
  logic [7:0]        s1_byte;
  logic [IDX_W-1:0]  s1_index;

  logic [ADDR_W-1:0] fill_count, fill_count_next;
  logic              ready_flag, ready_flag_next;
  logic              overrun_flag, overrun_flag_next;

  logic              out_valid;
  logic              out_is_read;
  logic [LEN_W-1:0]  out_length;
  logic              out_done;

  logic              advance;
  logic              done;
  logic              index_ok;
  logic              prev_bs;
  logic [7:0]        rd_data;
  store_ctrl_t       store_ctrl;

  assign advance   = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !s1_valid || advance;
  assign index_ok  = ({3'b000, s1_index} < 9'(STORE_DEPTH));

  always_comb begin
    fill_count_next   = fill_count;
    ready_flag_next   = ready_flag;
    overrun_flag_next = overrun_flag;
    done              = 1'b0;
    store_ctrl.we     = 1'b0;
    store_ctrl.waddr  = fill_count;
    store_ctrl.wdata  = s1_byte;
    if (advance) begin
      case (s1_cmd)
        CMD_BYTE: begin
          if (ready_flag) begin
            overrun_flag_next = 1'b1;
          end else if (s1_byte == CHAR_BACKSPACE) begin
            if (fill_count != '0) fill_count_next = fill_count - 1'b1;
          end else if (s1_byte == CHAR_CR && !(fill_count != '0 && prev_bs)) begin
            store_ctrl.we    = 1'b1;
            store_ctrl.wdata = 8'h00;
            done             = 1'b1;
            fill_count_next  = '0;
            ready_flag_next  = 1'b1;
          end else if (fill_count < ADDR_W'(STORE_DEPTH - 1)) begin
            store_ctrl.we   = 1'b1;
            fill_count_next = fill_count + 1'b1;
          end
        end
        CMD_RELEASE: begin
          ready_flag_next   = 1'b0;
          overrun_flag_next = 1'b0;
        end
        default: begin
        end
      endcase
    end
    store_ctrl.bs_raddr = fill_count_next - 1'b1;
    store_ctrl.rd_en    = advance;
    store_ctrl.rd_addr  = ADDR_W'(s1_index);
  end

  sla_store u_store (
    .clk     (clk),
    .ctrl    (store_ctrl),
    .rd_data (rd_data),
    .prev_bs (prev_bs)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      out_valid    <= 1'b0;
      fill_count   <= '0;
      ready_flag   <= 1'b0;
      overrun_flag <= 1'b0;
    end else begin
      fill_count   <= fill_count_next;
      ready_flag   <= ready_flag_next;
      overrun_flag <= overrun_flag_next;
      if (req.ready) s1_valid <= req.valid;
      if (advance) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
    if (req.valid && req.ready) begin
      s1_cmd   <= req.cmd;
      s1_byte  <= req.rx_byte;
      s1_index <= req.read_index;
    end
    if (advance) begin
      out_is_read <= (s1_cmd == CMD_READ) && index_ok;
      out_done    <= done;
      out_length  <= done ? LEN_W'(fill_count) : LEN_W'(fill_count_next);
    end
  end

  // Flags are kept live in the state registers; they are latched alongside.
  logic out_ready_flag, out_overrun;
  always_ff @(posedge clk) begin
    if (advance) begin
      out_ready_flag <= ready_flag_next;
      out_overrun    <= overrun_flag_next;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.line_ready  = out_ready_flag;
  assign rsp.overrun     = out_overrun;
  assign rsp.line_done   = out_done;
  assign rsp.line_length = out_length;
  assign rsp.read_data   = out_is_read ? rd_data : 8'h00;

`ifndef SYNTHESIS
  a_overrun_needs_ready: assert property (@(posedge clk) disable iff (rst)
    overrun_flag |-> ready_flag)
    else $error("overrun flag set without a waiting line");

  a_close_clears_count: assert property (@(posedge clk) disable iff (rst)
    (advance && done) |=> (fill_count == '0 && ready_flag))
    else $error("closing a line did not reset the count and set ready");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !req.ready |-> (s1_valid && out_valid))
    else $error("request stalled with room in the pipeline");

  a_done_reports_ready: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.line_done) |-> rsp.line_ready)
    else $error("closed line reported without ready");
`endif

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the serial line assembler. Command items are queued
// by a generator and sent by a clocked driver. A predictor updates its own
// copy of the line store and flags on each accepted item. A clocked monitor
// compares every result item field by field with the oldest prediction.
// Both channel ends idle at random, and the receiver holds off for long
// stretches so that the block fills up and stalls its input.
// ----------------------------------------------------------------------------
module tb;
  import sla_pkg::*;

  localparam logic [1:0] CMD_UNUSED  = 2'd3;
  localparam int         ITEM_TARGET = 1750;
  localparam int         HOLD_CYCLES = 300;
  localparam int         MAX_REPORTS = 100;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] rx_byte;
    logic [5:0] read_index;
  } cmd_item_t;

  typedef struct packed {
    logic       line_ready;
    logic       overrun;
    logic       line_done;
    logic [5:0] line_length;
    logic [7:0] read_data;
  } status_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sla_req_if req_ch ();
  sla_rsp_if rsp_ch ();

  serial_line_assembler dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #10 clk = ~clk;

  cmd_item_t pending_items[$];
  status_t   expected_status[$];

  // Predicted state of the block.
  logic [7:0]        line_mem [STORE_DEPTH];
  bit                line_mem_written [STORE_DEPTH];
  logic [ADDR_W-1:0] pred_fill    = '0;
  bit                pred_ready   = 1'b0;
  bit                pred_overrun = 1'b0;

  int n_taken      = 0;
  int n_queued     = 0;
  int n_mismatch   = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left    = 0;
  int hold_mark    = 400;

  initial begin
    req_ch.valid      = 1'b0;
    req_ch.cmd        = CMD_BYTE;
    req_ch.rx_byte    = 8'h00;
    req_ch.read_index = 6'd0;
    rsp_ch.ready      = 1'b0;
  end

  function automatic status_t assemble_step(cmd_item_t it);
    status_t s;
    s = '0;
    case (it.cmd)
      CMD_BYTE: begin
        if (pred_ready) begin
          pred_overrun = 1'b1;
        end else if (it.rx_byte == CHAR_BACKSPACE) begin
          if (pred_fill != '0) pred_fill--;
        end else if (it.rx_byte == CHAR_CR &&
                     !(pred_fill != '0 &&
                       line_mem[pred_fill - 1'b1] == CHAR_BACKSLASH)) begin
          line_mem[pred_fill] = 8'h00;
          line_mem_written[pred_fill] = 1'b1;
          s.line_done = 1'b1;
          s.line_length = pred_fill;
          pred_fill = '0;
          pred_ready = 1'b1;
        end else if (pred_fill < ADDR_W'(STORE_DEPTH - 1)) begin
          // An escaped carriage return lands here and is stored like any byte.
          line_mem[pred_fill] = it.rx_byte;
          line_mem_written[pred_fill] = 1'b1;
          pred_fill++;
        end
      end
      CMD_RELEASE: begin
        pred_ready = 1'b0;
        pred_overrun = 1'b0;
      end
      CMD_READ: begin
        if (it.read_index < STORE_DEPTH) s.read_data = line_mem[it.read_index];
      end
      default: ;
    endcase
    if (!s.line_done) s.line_length = pred_fill;
    s.line_ready = pred_ready;
    s.overrun = pred_overrun;
    return s;
  endfunction

  task automatic report_mismatch(string field, logic [7:0] got, logic [7:0] want);
    if (n_mismatch < MAX_REPORTS)
      $display("mismatch at %0t: %s got %h want %h", $realtime, field, got, want);
    n_mismatch++;
  endtask

  // Driver: a new item is presented only once the current one is taken.
  always @(posedge clk) begin : drive
    cmd_item_t cur;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (req_ch.valid) begin
        expected_status.push_back(assemble_step(cur));
        n_taken <= n_taken + 1;
      end
      if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cur = pending_items.pop_front();
        req_ch.valid      <= 1'b1;
        req_ch.cmd        <= cur.cmd;
        req_ch.rx_byte    <= cur.rx_byte;
        req_ch.read_index <= cur.read_index;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off now and then.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      rsp_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (n_taken >= hold_mark) begin
      rsp_ch.ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_mark <= hold_mark + 1000;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : monitor
    status_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_status.size() == 0) begin
        report_mismatch("unexpected result item", 8'h00, 8'h00);
      end else begin
        want = expected_status.pop_front();
        if (rsp_ch.line_ready !== want.line_ready)
          report_mismatch("line_ready", 8'(rsp_ch.line_ready), 8'(want.line_ready));
        if (rsp_ch.overrun !== want.overrun)
          report_mismatch("overrun", 8'(rsp_ch.overrun), 8'(want.overrun));
        if (rsp_ch.line_done !== want.line_done)
          report_mismatch("line_done", 8'(rsp_ch.line_done), 8'(want.line_done));
        if (rsp_ch.line_length !== want.line_length)
          report_mismatch("line_length", 8'(rsp_ch.line_length), 8'(want.line_length));
        if (rsp_ch.read_data !== want.read_data)
          report_mismatch("read_data", rsp_ch.read_data, want.read_data);
      end
    end
  end

  task automatic queue_item(logic [1:0] cmd, logic [7:0] b, logic [5:0] idx);
    pending_items.push_back('{cmd: cmd, rx_byte: b, read_index: idx});
    n_queued++;
  endtask

  task automatic queue_byte(logic [7:0] b);
    queue_item(CMD_BYTE, b, 6'($urandom_range(63)));
  endtask

  // Reads only target entries already written when the session was built;
  // entries never become unwritten, so the choice stays valid.
  function automatic int pick_written();
    int idx_list[$];
    for (int i = 0; i < STORE_DEPTH; i++)
      if (line_mem_written[ADDR_W'(i)]) idx_list.push_back(i);
    if (idx_list.size() == 0) return -1;
    return idx_list[$urandom_range(idx_list.size() - 1)];
  endfunction

  task automatic queue_read();
    int idx;
    idx = pick_written();
    if (idx >= 0) queue_item(CMD_READ, 8'($urandom_range(255)), 6'(idx));
  endtask

  task automatic line_session();
    int len;
    int r;
    len = ($urandom_range(99) < 15) ? $urandom_range(90, 75) : $urandom_range(12, 0);
    for (int k = 0; k < len; k++) begin
      r = $urandom_range(99);
      if (r < 6) begin
        queue_byte(CHAR_BACKSPACE);
      end else if (r < 10) begin
        queue_byte(CHAR_BACKSLASH);
      end else if (r < 13) begin
        queue_byte(CHAR_BACKSLASH);
        queue_byte(CHAR_CR);
      end else begin
        queue_byte(8'($urandom_range(255)));
      end
    end
    queue_byte(CHAR_CR);
    if ($urandom_range(99) < 30)
      repeat ($urandom_range(3, 1)) queue_byte(8'($urandom_range(255)));
    repeat ($urandom_range(4, 0)) queue_read();
    if ($urandom_range(99) < 90)
      queue_item(CMD_RELEASE, 8'($urandom_range(255)), 6'($urandom_range(63)));
  endtask

  task automatic noise_session();
    logic [1:0] cmd;
    int idx;
    repeat (12) begin
      cmd = 2'($urandom_range(3));
      if (cmd == CMD_READ) begin
        idx = pick_written();
        if (idx < 0) cmd = CMD_UNUSED;
        else queue_item(CMD_READ, 8'($urandom_range(255)), 6'(idx));
      end
      if (cmd != CMD_READ)
        queue_item(cmd, 8'($urandom_range(255)), 6'($urandom_range(63)));
    end
  endtask

  initial begin : stimulus
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Empty line closes at once, then a byte while it waits overruns.
    queue_byte(CHAR_CR);
    queue_byte(8'h41);
    queue_item(CMD_READ, 8'hFF, 6'd0);
    queue_item(CMD_RELEASE, 8'h00, 6'd63);
    queue_item(CMD_UNUSED, 8'hAA, 6'd21);
    // Backspace with nothing held, then an escaped carriage return.
    queue_byte(CHAR_BACKSPACE);
    queue_byte(8'hFF);
    queue_byte(8'h00);
    queue_byte(CHAR_BACKSLASH);
    queue_byte(CHAR_CR);
    queue_byte(8'h78);
    queue_byte(CHAR_BACKSPACE);
    queue_byte(CHAR_CR);
    queue_item(CMD_READ, 8'h00, 6'd0);
    queue_item(CMD_READ, 8'h00, 6'd1);
    queue_item(CMD_READ, 8'h55, 6'd2);
    queue_item(CMD_READ, 8'h00, 6'd3);
    queue_item(CMD_READ, 8'h00, 6'd4);
    queue_item(CMD_RELEASE, 8'hFF, 6'd0);
    while (pending_items.size() != 0) @(negedge clk);

    while (n_queued < ITEM_TARGET) begin
      if (n_queued >= 1200) begin
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
      end else if (n_queued >= 600) begin
        send_idle_pct <= 84;
        recv_idle_pct <= 33;
      end else begin
        send_idle_pct <= 33;
        recv_idle_pct <= 84;
      end
      if ($urandom_range(99) < 75) line_session();
      else noise_session();
      while (pending_items.size() != 0) @(negedge clk);
    end

    while (pending_items.size() != 0 || req_ch.valid || expected_status.size() != 0)
      @(negedge clk);
    repeat (20) @(negedge clk);
    if (n_mismatch == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
